### sv/rrqs_pkg.sv
// shared types and codes for the round-robin quantum scheduler
package rrqs_pkg;

  // command codes on the input func field
  localparam logic [1:0] FUNC_APPEND = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_ROUND  = 2'd2;
  localparam logic [1:0] FUNC_REMOVE = 2'd3;

  // event codes on the result event_res field
  localparam logic [2:0] EV_APPENDED  = 3'd0;
  localparam logic [2:0] EV_FRONT     = 3'd1;
  localparam logic [2:0] EV_PARTIAL   = 3'd2;
  localparam logic [2:0] EV_COMPLETED = 3'd3;
  localparam logic [2:0] EV_REMOVED   = 3'd4;
  localparam logic [2:0] EV_EMPTY     = 3'd5;
  localparam logic [2:0] EV_NOTFOUND  = 3'd6;
  localparam logic [2:0] EV_FULL      = 3'd7;

  localparam logic [15:0] QUANTUM_RESET = 16'd4;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  task_id;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  result_id;
    logic [15:0] time_left;
    logic        last;
  } out_item_t;

  // one queue entry as stored in the ram
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] time_left;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic {
    ST_IDLE,
    ST_PASS
  } state_t;

endpackage

### sv/rrqs_ram.sv
// generic simple dual-port ram with one write port and a registered read port
module rrqs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### sv/rrqs_outreg.sv
// result output register with valid/stall handshake
module rrqs_outreg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  rrqs_pkg::out_item_t load_item,
  input  logic                out_stall,
  output logic                out_valid,
  output rrqs_pkg::out_item_t out_data,
  output logic                free
);

  logic                valid_r;
  logic                valid_nxt;
  rrqs_pkg::out_item_t data_r;

  // register can take a new result when empty or being drained
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### sv/round_robin_quantum_scheduler.sv
// round-robin task queue with time quantum, held in a circular ram
// every result passes through the registered output stage
// append, insert and commands on an empty queue load their one result on acceptance
// a round or a remove over N queued tasks first reads the head from the ram, then
// does one ram read/modify/write per task; an output stall holds the pass
// reset (rst_n, synchronous): queue empty, quantum 4, no result pending
module round_robin_quantum_scheduler #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                in_valid,
  output logic                in_stall,
  input  rrqs_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output rrqs_pkg::out_item_t out_data,
  // quantum register write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [15:0]         cfg_data
);

  // ram address width and queue count width (count can reach QUEUE_DEPTH)
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // map a logical queue position to a ram address, base + offset wrapped once
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] ofs);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, ofs};
    if (s >= (CW + 1)'(QUEUE_DEPTH)) begin
      s = s - (CW + 1)'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // control state
  rrqs_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    head_r, head_nxt;      // ram address of queue position 0
  logic [CW-1:0]    occ_r, occ_nxt;        // number of queued tasks
  logic [7:0]       head_id_r, head_id_nxt; // copy of the head task's id for insert
  logic [CW-1:0]    rd_ptr_r, rd_ptr_nxt;  // position whose data is at the ram output
  logic [CW-1:0]    wr_ptr_r, wr_ptr_nxt;  // compaction write position
  logic [CW-1:0]    total_r, total_nxt;    // tasks visited by this pass
  logic [1:0]       cmd_func_r, cmd_func_nxt;
  logic [7:0]       cmd_id_r, cmd_id_nxt;
  logic             found_r, found_nxt;    // remove already took its match
  logic [15:0]      quantum_r;

  // ram interface
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  rrqs_pkg::entry_t    ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [rrqs_pkg::ENTRY_W-1:0] ram_rdata;
  rrqs_pkg::entry_t    cur;

  // output register interface
  logic                out_load;
  rrqs_pkg::out_item_t out_item;
  logic                out_free;

  logic                in_fire;
  logic                last_entry;
  logic [15:0]         t_sub;

  assign cur        = ram_rdata;
  assign cfg_ready  = 1'b1;
  assign in_stall   = (state_r != rrqs_pkg::ST_IDLE) || !out_free;
  assign in_fire    = in_valid && !in_stall;
  assign last_entry = (rd_ptr_r == total_r - CW'(1));
  assign t_sub      = cur.time_left - quantum_r;

  rrqs_ram #(
    .WIDTH (rrqs_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  rrqs_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .load_item (out_item),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .free      (out_free)
  );

  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    occ_nxt      = occ_r;
    head_id_nxt  = head_id_r;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    total_nxt    = total_r;
    cmd_func_nxt = cmd_func_r;
    cmd_id_nxt   = cmd_id_r;
    found_nxt    = found_r;
    ram_we       = 1'b0;
    ram_waddr    = head_r;
    ram_wdata    = '0;
    ram_raddr    = head_r;  // idle: keep the head on the read port for a pass start
    out_load     = 1'b0;
    out_item     = '0;

    case (state_r)
      rrqs_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          out_item.last = 1'b1;
          if (in_data.func == rrqs_pkg::FUNC_APPEND ||
              in_data.func == rrqs_pkg::FUNC_INSERT) begin
            out_item.result_id = in_data.task_id;
            if (occ_r == CW'(QUEUE_DEPTH)) begin
              out_item.event_res = rrqs_pkg::EV_FULL;
            end else if (in_data.func == rrqs_pkg::FUNC_INSERT && occ_r != '0 &&
                         in_data.task_id < head_id_r) begin
              // preempt: move the head back one slot and write there
              head_nxt = (head_r == '0) ? AW'(QUEUE_DEPTH - 1) : head_r - AW'(1);
              ram_we    = 1'b1;
              ram_waddr = head_nxt;
              ram_wdata = '{id: in_data.task_id, time_left: in_data.burst_time};
              occ_nxt   = occ_r + CW'(1);
              head_id_nxt = in_data.task_id;
              out_item.event_res = rrqs_pkg::EV_FRONT;
              out_item.time_left = in_data.burst_time;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = phys(head_r, occ_r);
              ram_wdata = '{id: in_data.task_id, time_left: in_data.burst_time};
              occ_nxt   = occ_r + CW'(1);
              if (occ_r == '0) begin
                head_id_nxt = in_data.task_id;
              end
              out_item.event_res = rrqs_pkg::EV_APPENDED;
              out_item.time_left = in_data.burst_time;
            end
          end else if (occ_r == '0) begin
            // round or remove on an empty queue
            out_item.event_res = rrqs_pkg::EV_EMPTY;
            out_item.result_id = (in_data.func == rrqs_pkg::FUNC_REMOVE) ?
                                 in_data.task_id : 8'd0;
          end else begin
            // start a compaction pass over every queued task
            out_load     = 1'b0;
            state_nxt    = rrqs_pkg::ST_PASS;
            rd_ptr_nxt   = '0;
            wr_ptr_nxt   = '0;
            total_nxt    = occ_r;
            cmd_func_nxt = in_data.func;
            cmd_id_nxt   = in_data.task_id;
            found_nxt    = 1'b0;
          end
        end
      end

      rrqs_pkg::ST_PASS: begin
        ram_raddr = phys(head_r, rd_ptr_r);  // hold the read while stalled
        if (out_free) begin
          if (cmd_func_r == rrqs_pkg::FUNC_ROUND) begin
            out_load = 1'b1;
            out_item.result_id = cur.id;
            out_item.last      = last_entry;
            if (cur.time_left <= quantum_r) begin
              // task completes and drops out of the queue
              out_item.event_res = rrqs_pkg::EV_COMPLETED;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = phys(head_r, wr_ptr_r);
              ram_wdata  = '{id: cur.id, time_left: t_sub};
              wr_ptr_nxt = wr_ptr_r + CW'(1);
              if (wr_ptr_r == '0) begin
                head_id_nxt = cur.id;
              end
              out_item.event_res = rrqs_pkg::EV_PARTIAL;
              out_item.time_left = t_sub;
            end
          end else begin
            // remove: skip the first matching id, keep the rest in order
            if (!found_r && cur.id == cmd_id_r) begin
              found_nxt = 1'b1;
            end else begin
              ram_we     = 1'b1;
              ram_waddr  = phys(head_r, wr_ptr_r);
              ram_wdata  = cur;
              wr_ptr_nxt = wr_ptr_r + CW'(1);
              if (wr_ptr_r == '0) begin
                head_id_nxt = cur.id;
              end
            end
            if (last_entry) begin
              out_load = 1'b1;
              out_item.event_res = found_nxt ? rrqs_pkg::EV_REMOVED :
                                               rrqs_pkg::EV_NOTFOUND;
              out_item.result_id = cmd_id_r;
              out_item.last      = 1'b1;
            end
          end
          rd_ptr_nxt = rd_ptr_r + CW'(1);
          ram_raddr  = phys(head_r, rd_ptr_nxt);
          if (last_entry) begin
            occ_nxt   = wr_ptr_nxt;
            state_nxt = rrqs_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = rrqs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rrqs_pkg::ST_IDLE;
      head_r    <= '0;
      occ_r     <= '0;
      quantum_r <= rrqs_pkg::QUANTUM_RESET;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      occ_r   <= occ_nxt;
      if (cfg_valid && cfg_ready) begin
        quantum_r <= cfg_data;
      end
    end
  end

  // pass bookkeeping and head id copy, only meaningful while the queue is in use
  always_ff @(posedge clk) begin
    head_id_r  <= head_id_nxt;
    rd_ptr_r   <= rd_ptr_nxt;
    wr_ptr_r   <= wr_ptr_nxt;
    total_r    <= total_nxt;
    cmd_func_r <= cmd_func_nxt;
    cmd_id_r   <= cmd_id_nxt;
    found_r    <= found_nxt;
  end

endmodule

### sv/rrqs_checker.sv
// port-level checks for the round-robin quantum scheduler, bound to the top level
module rrqs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input rrqs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input rrqs_pkg::out_item_t out_data,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [15:0]         cfg_data
);

  // no result left over from before reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // only a partial run leaves time on a reported task besides append and insert
  a_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == rrqs_pkg::EV_COMPLETED ||
                  out_data.event_res == rrqs_pkg::EV_REMOVED ||
                  out_data.event_res == rrqs_pkg::EV_EMPTY ||
                  out_data.event_res == rrqs_pkg::EV_NOTFOUND ||
                  out_data.event_res == rrqs_pkg::EV_FULL) |-> out_data.time_left == 16'd0)
    else $error("nonzero time on a terminal event");

  // every event outside a round is the only result of its command
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.event_res == rrqs_pkg::EV_APPENDED ||
                  out_data.event_res == rrqs_pkg::EV_FRONT ||
                  out_data.event_res == rrqs_pkg::EV_REMOVED ||
                  out_data.event_res == rrqs_pkg::EV_EMPTY ||
                  out_data.event_res == rrqs_pkg::EV_NOTFOUND ||
                  out_data.event_res == rrqs_pkg::EV_FULL) |-> out_data.last)
    else $error("single-result event without last");

  // no new command is taken while a result that is not the last of its command is held back
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall && !out_data.last |-> in_stall)
    else $error("command accepted in the middle of a round");

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (.*);
